// ----- hdl/hciod_pkg.sv -----
// package for the partial-address i/o port decoder
// holds transaction types, op codes, register indexes and decode constants
// no dependencies
package hciod_pkg;

   localparam int unsigned ROWS = 8;

   localparam logic [2:0] OP_IO_READ  = 3'd0;
   localparam logic [2:0] OP_IO_WRITE = 3'd1;
   localparam logic [2:0] OP_KEY_ROW  = 3'd2;
   localparam logic [2:0] OP_PAD_ROW  = 3'd3;
   localparam logic [2:0] OP_JOYSTICK = 3'd4;

   localparam logic [7:0] CSR_EAR_ENABLE   = 8'd0;
   localparam logic [7:0] CSR_SOUND_ENABLE = 8'd1;

   localparam logic [7:0] KEY_HIGH_EAR  = 8'hFE;
   localparam logic [7:0] FLOATING_BUS  = 8'hA0;
   localparam logic [7:0] ROW_IDLE      = 8'hFF;
   localparam int unsigned EAR_BIT      = 6;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] port_low;
      logic [7:0] port_high;
      logic [7:0] data_byte;
      logic [2:0] row_index;
      logic       ear_level;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_from_sound_chip;
      logic       sound_reg_select;
      logic       sound_reg_write;
      logic [2:0] border_color;
      logic       speaker_level;
      logic       mic_level;
      logic [2:0] bank_select;
      logic [1:0] rom_select;
      logic       video_page;
      logic       paging_locked;
      logic       special_mode;
   } rsp_payload_type;

endpackage

// ----- hdl/home_computer_io_port_decoder.sv -----
// top level of the partial-address i/o port decoder
// depends on hciod_pkg for transaction types, op codes and constants
//
// Decodes CPU i/o reads and writes by partial address and keeps the keyboard
// matrices, joystick byte, border/speaker/mic latches and paging latches.
// Every request transaction gives exactly one response transaction. A request
// passes the input register, then the result register; one transaction is
// taken every cycle while rsp_stall is low, and an item may be accepted while
// a finished result still waits. Latch fields in a response show the values
// after that transaction. CSR writes are taken at any time (csr_ready is
// always high) and are meant to happen only while the block is idle.
module home_computer_io_port_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hciod_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hciod_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [7:0]               csr_index,
   input  logic                     csr_data
);
   import hciod_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            advance;

   logic            ear_enable_ff, ear_enable_in;
   logic            sound_enable_ff, sound_enable_in;
   logic [7:0]      key_rows_ff [ROWS];
   logic [7:0]      key_rows_in [ROWS];
   logic [7:0]      pad_rows_ff [ROWS];
   logic [7:0]      pad_rows_in [ROWS];
   logic [7:0]      joystick_ff, joystick_in;
   logic [2:0]      border_ff, border_in;
   logic            speaker_ff, speaker_in;
   logic            mic_ff, mic_in;
   logic [2:0]      bank_ff, bank_in;
   logic            rom_latch_ff, rom_latch_in;
   logic            rom_second_ff, rom_second_in;
   logic            video_ff, video_in;
   logic            lock_ff, lock_in;
   logic            mode_ff, mode_in;

   logic [7:0]      key_value;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // handshake
   always_comb begin
      in_valid_in = in_valid_ff;
      if (~req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // configuration
   always_comb begin
      ear_enable_in   = ear_enable_ff;
      sound_enable_in = sound_enable_ff;
      if (csr_valid & csr_ready) begin
         if (csr_index == CSR_EAR_ENABLE) begin
            ear_enable_in = csr_data;
         end
         if (csr_index == CSR_SOUND_ENABLE) begin
            sound_enable_in = csr_data;
         end
      end
   end

   // keyboard read: and together all rows selected by a low high-address bit
   always_comb begin
      key_value = ROW_IDLE;
      if (ear_enable_ff && in_ff.port_high == KEY_HIGH_EAR) begin
         key_value[EAR_BIT] = in_ff.ear_level;
      end
      for (int i = 0; i < ROWS; i++) begin
         if (!in_ff.port_high[i]) begin
            key_value = key_value & key_rows_ff[i] & pad_rows_ff[i];
         end
      end
   end

   // decode and state update
   always_comb begin
      key_rows_in   = key_rows_ff;
      pad_rows_in   = pad_rows_ff;
      joystick_in   = joystick_ff;
      border_in     = border_ff;
      speaker_in    = speaker_ff;
      mic_in        = mic_ff;
      bank_in       = bank_ff;
      rom_latch_in  = rom_latch_ff;
      rom_second_in = rom_second_ff;
      video_in      = video_ff;
      lock_in       = lock_ff;
      mode_in       = mode_ff;
      out_in        = '0;

      unique case (in_ff.op)
         OP_IO_READ: begin
            priority if (!in_ff.port_low[0]) begin
               out_in.read_data = key_value;
            end else if (in_ff.port_low[7:5] == 3'b000) begin
               out_in.read_data = joystick_ff;
            end else if (sound_enable_ff && in_ff.port_high[7:6] == 2'b11
                         && !in_ff.port_low[1]) begin
               out_in.read_from_sound_chip = 1'b1;
            end else begin
               out_in.read_data = FLOATING_BUS;
            end
         end
         OP_IO_WRITE: begin
            if (!in_ff.port_low[0]) begin
               border_in  = in_ff.data_byte[2:0];
               speaker_in = in_ff.data_byte[4];
               mic_in     = in_ff.data_byte[3];
            end
            if (!in_ff.port_low[1]) begin
               if (sound_enable_ff && in_ff.port_high[7]) begin
                  out_in.sound_reg_select = in_ff.port_high[6];
                  out_in.sound_reg_write  = ~in_ff.port_high[6];
               end
               if (in_ff.port_high[7:6] == 2'b01) begin
                  lock_in      = in_ff.data_byte[5];
                  rom_latch_in = in_ff.data_byte[4];
                  video_in     = in_ff.data_byte[3];
                  bank_in      = in_ff.data_byte[2:0];
               end
               if (in_ff.port_high[7:4] == 4'b0001) begin
                  mode_in       = in_ff.data_byte[0];
                  rom_second_in = in_ff.data_byte[2];
               end
            end
         end
         OP_KEY_ROW: begin
            key_rows_in[in_ff.row_index] = in_ff.data_byte;
         end
         OP_PAD_ROW: begin
            pad_rows_in[in_ff.row_index] = in_ff.data_byte;
         end
         OP_JOYSTICK: begin
            joystick_in = in_ff.data_byte;
         end
         default: begin
         end
      endcase

      out_in.border_color  = border_in;
      out_in.speaker_level = speaker_in;
      out_in.mic_level     = mic_in;
      out_in.bank_select   = bank_in;
      out_in.rom_select    = {rom_second_in, rom_latch_in};
      out_in.video_page    = video_in;
      out_in.paging_locked = lock_in;
      out_in.special_mode  = mode_in;
   end

   always_ff @(posedge clock) begin
      if (~req_stall) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         out_ff <= out_in;
      end
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         ear_enable_ff   <= 1'b1;
         sound_enable_ff <= 1'b1;
         for (int i = 0; i < ROWS; i++) begin
            key_rows_ff[i] <= ROW_IDLE;
            pad_rows_ff[i] <= ROW_IDLE;
         end
         joystick_ff   <= '0;
         border_ff     <= '0;
         speaker_ff    <= 1'b0;
         mic_ff        <= 1'b0;
         bank_ff       <= '0;
         rom_latch_ff  <= 1'b0;
         rom_second_ff <= 1'b0;
         video_ff      <= 1'b0;
         lock_ff       <= 1'b0;
         mode_ff       <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         ear_enable_ff   <= ear_enable_in;
         sound_enable_ff <= sound_enable_in;
         if (advance) begin
            key_rows_ff   <= key_rows_in;
            pad_rows_ff   <= pad_rows_in;
            joystick_ff   <= joystick_in;
            border_ff     <= border_in;
            speaker_ff    <= speaker_in;
            mic_ff        <= mic_in;
            bank_ff       <= bank_in;
            rom_latch_ff  <= rom_latch_in;
            rom_second_ff <= rom_second_in;
            video_ff      <= video_in;
            lock_ff       <= lock_in;
            mode_ff       <= mode_in;
         end
      end
   end

endmodule

// ----- verif/hciod_check_pkg.sv -----
// response checking for the partial-address i/o port decoder testbench
// depends on hciod_pkg for transaction types, op codes and register indexes
package hciod_check_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import hciod_pkg::*;

   class io_decode_scoreboard;
      bit ear_on;
      bit sound_on;
      logic [7:0] key_matrix [ROWS];
      logic [7:0] pad_matrix [ROWS];
      logic [7:0] stick;
      logic [2:0] border;
      logic beeper;
      logic mic_bit;
      logic [2:0] ram_bank;
      logic rom_low;
      logic rom_high;
      logic shadow_screen;
      logic page_lock;
      logic special_paging;
      rsp_payload_type pending [$];
      int unsigned errors;
      int unsigned checked;
      int unsigned requests;

      function new();
         ear_on = 1'b1;
         sound_on = 1'b1;
         foreach (key_matrix[i]) key_matrix[i] = ROW_IDLE;
         foreach (pad_matrix[i]) pad_matrix[i] = ROW_IDLE;
         stick = '0;
         border = '0;
         beeper = 1'b0;
         mic_bit = 1'b0;
         ram_bank = '0;
         rom_low = 1'b0;
         rom_high = 1'b0;
         shadow_screen = 1'b0;
         page_lock = 1'b0;
         special_paging = 1'b0;
         errors = 0;
         checked = 0;
         requests = 0;
      endfunction

      function void write_reg(logic [7:0] index, logic value);
         case (index)
            CSR_EAR_ENABLE: ear_on = value;
            CSR_SOUND_ENABLE: sound_on = value;
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return pending.size();
      endfunction

      // work out the response of one accepted request transaction
      function void note_request(req_payload_type r);
         rsp_payload_type want;
         logic [7:0] rows;
         want = '0;
         requests++;
         case (r.op)
            OP_IO_READ: begin
               if (!r.port_low[0]) begin
                  rows = ROW_IDLE;
                  if (ear_on && r.port_high == KEY_HIGH_EAR) rows[EAR_BIT] = r.ear_level;
                  for (int i = 0; i < ROWS; i++)
                     if (!r.port_high[i]) rows &= key_matrix[i] & pad_matrix[i];
                  want.read_data = rows;
               end else if (r.port_low[7:5] == 3'b000) begin
                  want.read_data = stick;
               end else if (sound_on && r.port_high[7:6] == 2'b11 && !r.port_low[1]) begin
                  want.read_from_sound_chip = 1'b1;
               end else begin
                  want.read_data = FLOATING_BUS;
               end
            end
            OP_IO_WRITE: begin
               if (!r.port_low[0]) begin
                  border = r.data_byte[2:0];
                  beeper = r.data_byte[4];
                  mic_bit = r.data_byte[3];
               end
               if (!r.port_low[1]) begin
                  if (sound_on && r.port_high[7]) begin
                     if (r.port_high[6]) want.sound_reg_select = 1'b1;
                     else want.sound_reg_write = 1'b1;
                  end
                  if (r.port_high[7:6] == 2'b01) begin
                     page_lock = r.data_byte[5];
                     rom_low = r.data_byte[4];
                     shadow_screen = r.data_byte[3];
                     ram_bank = r.data_byte[2:0];
                  end
                  if (r.port_high[7:4] == 4'b0001) begin
                     special_paging = r.data_byte[0];
                     rom_high = r.data_byte[2];
                  end
               end
            end
            OP_KEY_ROW: key_matrix[r.row_index] = r.data_byte;
            OP_PAD_ROW: pad_matrix[r.row_index] = r.data_byte;
            OP_JOYSTICK: stick = r.data_byte;
            default: ;
         endcase
         want.border_color = border;
         want.speaker_level = beeper;
         want.mic_level = mic_bit;
         want.bank_select = ram_bank;
         want.rom_select = {rom_high, rom_low};
         want.video_page = shadow_screen;
         want.paging_locked = page_lock;
         want.special_mode = special_paging;
         pending.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            $display("%0t: response %h with no transaction waiting", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("read_from_sound_chip", want.read_from_sound_chip,
                       got.read_from_sound_chip);
         compare_field("sound_reg_select", want.sound_reg_select, got.sound_reg_select);
         compare_field("sound_reg_write", want.sound_reg_write, got.sound_reg_write);
         compare_field("border_color", want.border_color, got.border_color);
         compare_field("speaker_level", want.speaker_level, got.speaker_level);
         compare_field("mic_level", want.mic_level, got.mic_level);
         compare_field("bank_select", want.bank_select, got.bank_select);
         compare_field("rom_select", want.rom_select, got.rom_select);
         compare_field("video_page", want.video_page, got.video_page);
         compare_field("paging_locked", want.paging_locked, got.paging_locked);
         compare_field("special_mode", want.special_mode, got.special_mode);
      endfunction

      function bit clean();
         if (pending.size() != 0)
            $display("%0t: %0d expected responses never arrived", $time, pending.size());
         return errors == 0 && pending.size() == 0;
      endfunction
   endclass

endpackage

// ----- verif/home_computer_io_port_decoder_test.sv -----
// testbench top for the partial-address i/o port decoder
// depends on hciod_pkg and on hciod_check_pkg for the scoreboard
// directed and random request transactions under random stalls and all four csr settings
module home_computer_io_port_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hciod_pkg::*;
   import hciod_check_pkg::*;

   localparam logic [2:0] OP_SPARE_FIRST = OP_JOYSTICK + 3'd1;
   localparam logic [2:0] OP_SPARE_LAST = 3'b111;
   localparam int unsigned IDLE_PERCENT = 8;
   localparam int unsigned PHASE_ITEMS = 485;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam int unsigned TIMEOUT_NS = 400_000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [7:0] csr_index;
   logic csr_data;

   io_decode_scoreboard book = new();
   bit sender_gaps;
   bit receiver_gaps;
   bit hold_request;
   int unsigned hold_left;

   home_computer_io_port_decoder u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   // response side: check every accepted transaction, random and long stalls
   initial begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) book.check_response(rsp_payload);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_gaps && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   task automatic send_item(input req_payload_type p);
      while (sender_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(p);
   endtask

   task automatic issue(input logic [2:0] op, input logic [7:0] lo, input logic [7:0] hi,
                        input logic [7:0] data, input logic [2:0] row, input logic ear);
      req_payload_type p;
      p.op = op;
      p.port_low = lo;
      p.port_high = hi;
      p.data_byte = data;
      p.row_index = row;
      p.ear_level = ear;
      send_item(p);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.write_reg(index, value);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic ear, input logic snd);
      write_csr(CSR_EAR_ENABLE, ear);
      write_csr(CSR_SOUND_ENABLE, snd);
   endtask

   function automatic req_payload_type random_item();
      req_payload_type p;
      int unsigned pick;
      p.port_low = 8'($urandom);
      p.port_high = 8'($urandom);
      p.data_byte = 8'($urandom);
      p.row_index = 3'($urandom);
      p.ear_level = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) p.op = OP_IO_READ;
      else if (pick < 70) p.op = OP_IO_WRITE;
      else if (pick < 80) p.op = OP_KEY_ROW;
      else if (pick < 88) p.op = OP_PAD_ROW;
      else if (pick < 95) p.op = OP_JOYSTICK;
      else p.op = OP_SPARE_FIRST + 3'($urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
      // row updates mostly release keys or press one
      if ((p.op == OP_KEY_ROW || p.op == OP_PAD_ROW) && $urandom_range(0, 3) != 0)
         p.data_byte = $urandom_range(0, 1) ? ROW_IDLE : ~(8'd1 << $urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: p.port_low[0] = 1'b0;
         1: p.port_low[1:0] = 2'b01;
         2: p.port_low = {3'b000, p.port_low[4:1], 1'b1};
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: p.port_high = KEY_HIGH_EAR;
         1: p.port_high = ~(8'd1 << $urandom_range(0, 7));
         2: p.port_high[7:6] = 2'b01;
         3: p.port_high[7:4] = 4'b0001;
         4: p.port_high[7:6] = 2'b11;
         default: ;
      endcase
      return p;
   endfunction

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= 1'b0;
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      hold_request = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      apply_setting(1'b1, 1'b1);

      // keyboard, ear and matrix corners
      issue(OP_IO_READ, 8'hFE, KEY_HIGH_EAR, 8'h00, 3'd0, 1'b0);
      issue(OP_IO_READ, 8'hFE, KEY_HIGH_EAR, 8'hFF, 3'd7, 1'b1);
      issue(OP_KEY_ROW, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0);
      issue(OP_KEY_ROW, 8'hFF, 8'hFF, 8'h55, 3'd7, 1'b1);
      issue(OP_PAD_ROW, 8'h00, 8'h00, 8'hAA, 3'd3, 1'b0);
      issue(OP_IO_READ, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1);
      issue(OP_IO_READ, 8'hFE, KEY_HIGH_EAR, 8'h00, 3'd0, 1'b1);
      issue(OP_IO_READ, 8'hFE, 8'h7F, 8'h00, 3'd0, 1'b0);
      issue(OP_IO_READ, 8'h00, 8'hFF, 8'h00, 3'd0, 1'b1);
      // joystick, sound chip and floating reads
      issue(OP_JOYSTICK, 8'h00, 8'h00, 8'hFF, 3'd0, 1'b0);
      issue(OP_IO_READ, 8'h1F, 8'h00, 8'h00, 3'd0, 1'b0);
      issue(OP_IO_READ, 8'hFD, 8'hFF, 8'h00, 3'd0, 1'b0);
      issue(OP_IO_READ, 8'hFF, 8'hFF, 8'h00, 3'd0, 1'b0);
      // ula, paging and sound chip writes
      issue(OP_IO_WRITE, 8'hFE, 8'hFF, 8'hFF, 3'd0, 1'b0);
      issue(OP_IO_WRITE, 8'hFD, 8'h7F, 8'h3F, 3'd0, 1'b0);
      issue(OP_IO_WRITE, 8'hFD, 8'h1F, 8'h05, 3'd0, 1'b0);
      issue(OP_IO_WRITE, 8'hFD, 8'hFF, 8'h07, 3'd0, 1'b0);
      issue(OP_IO_WRITE, 8'hFD, 8'hBF, 8'hAA, 3'd0, 1'b0);
      issue(OP_IO_WRITE, 8'h00, 8'h40, 8'h00, 3'd0, 1'b0);
      // paging still follows writes while locked
      issue(OP_IO_WRITE, 8'hFD, 8'h7F, 8'h20, 3'd0, 1'b0);
      issue(OP_IO_WRITE, 8'hFD, 8'h7F, 8'h17, 3'd0, 1'b0);
      issue(OP_SPARE_LAST, 8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b1);
      issue(OP_JOYSTICK, 8'hFF, 8'hFF, 8'h00, 3'd0, 1'b1);
      issue(OP_KEY_ROW, 8'h00, 8'h00, ROW_IDLE, 3'd0, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: apply_setting(1'b0, 1'b0);
            1: apply_setting(1'b1, 1'b0);
            2: apply_setting(1'b0, 1'b1);
            default: apply_setting(1'b1, 1'b1);
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // phase 1 opens with a long stretch at full rate
            sender_gaps = !(phase == 1 && n < 250);
            receiver_gaps = sender_gaps;
            if (phase == 2 && n == 150) hold_request = 1'b1;
            if (phase == 3 && n == 200) wait_idle();
            send_item(random_item());
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d responses checked, four csr settings,",
               book.requests, book.checked);
      $display("a long response hold-off and drained pauses between bursts");
      if (book.clean()) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
